### rtl/core/slab_pkg.sv
// ----------------------------------------------------------------------------
// slab_pkg
// Shared types and codes for the slab allocator.
// ----------------------------------------------------------------------------
package slab_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_FRAME = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic start;
    } slab_cmd_t;

    typedef struct packed {
        logic busy;
    } slab_stat_t;

endpackage

### rtl/core/slab_ctrl.sv
// ----------------------------------------------------------------------------
// slab_ctrl
// Sequencer: takes a request, runs the datapath, holds the result.
// ----------------------------------------------------------------------------
module slab_ctrl
    import slab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  slab_stat_t stat,
    output slab_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign cmd.start  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_RUN;
            S_RUN:  if (!stat.busy) state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/slab_dp.sv
// ----------------------------------------------------------------------------
// slab_dp
// Per-frame and per-pool bookkeeping, slot link memory, result registers.
// Phases: decode/lookup, link read, commit.
// ----------------------------------------------------------------------------
module slab_dp
    import slab_pkg::*;
#(
    parameter int MIN_ORDER  = 4,
    parameter int MAX_ORDER  = 11,
    parameter int SLAB_BYTES = 4096,
    parameter int NUM_FRAMES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  slab_cmd_t   cmd,
    output slab_stat_t  stat,
    input  logic [33:0] in_data,
    output logic [18:0] out_data
);

    localparam int NCLS  = (MAX_ORDER >= MIN_ORDER) ? MAX_ORDER - MIN_ORDER + 1 : 1;
    localparam int NPOOL = 2 * NCLS;
    localparam int MAXS  = ((SLAB_BYTES >> MIN_ORDER) > 0) ? (SLAB_BYTES >> MIN_ORDER) : 1;
    localparam int SW    = (MAXS > 1) ? $clog2(MAXS) : 1;
    localparam int CW    = $clog2(MAXS + 1);
    localparam int FW    = $clog2(NUM_FRAMES + 1);
    localparam int FIW   = $clog2(NUM_FRAMES);
    localparam int PW    = (NPOOL > 1) ? $clog2(NPOOL) : 1;
    localparam int OW    = 5;
    localparam int BSH   = $clog2(SLAB_BYTES);
    localparam logic [FW-1:0] NOF = FW'(NUM_FRAMES);

    logic          fin_use_reg [NUM_FRAMES];
    logic [PW-1:0] fcls_reg    [NUM_FRAMES];
    logic [CW-1:0] fcnt_reg    [NUM_FRAMES];
    logic [SW-1:0] fhead_reg   [NUM_FRAMES];
    logic          fhnil_reg   [NUM_FRAMES];
    logic [CW-1:0] fmark_reg   [NUM_FRAMES];
    logic [FW-1:0] pnext_reg   [NUM_FRAMES];
    logic [FW-1:0] pprev_reg   [NUM_FRAMES];
    logic [FW-1:0] pcur_reg    [NPOOL];
    logic [FW-1:0] phead_reg   [NPOOL];
    logic [FW-1:0] ptail_reg   [NPOOL];
    logic [SW:0]   link_mem    [NUM_FRAMES*MAXS];

    logic [1:0]    ph_reg;
    logic          op_reg, fail_reg;
    logic [1:0]    st_reg;
    logic [PW-1:0] p_reg;
    logic [OW-1:0] o_reg;
    logic [FW-1:0] f_reg;
    logic [SW-1:0] s_reg;
    logic [15:0]   fa_reg;
    logic          newf_reg;
    logic [SW:0]   lrd_reg;
    logic [18:0]   out_reg;

    logic [15:0] sz, fa;
    logic        iop, icode;
    assign iop   = in_data[0];
    assign sz    = in_data[16:1];
    assign icode = in_data[17];
    assign fa    = in_data[33:18];

    function automatic logic [CW-1:0] slots_of(input logic [OW-1:0] o);
        logic [CW-1:0] n;
        n = CW'(32'(SLAB_BYTES) >> o);
        return (n == '0) ? CW'(1) : n;
    endfunction

    logic [OW-1:0] ord;
    logic          big;
    logic [FW-1:0] lowf;
    always_comb
    begin
        ord = OW'(MIN_ORDER);
        for (int k = MIN_ORDER + 1; k <= MAX_ORDER; k++)
            if (32'(sz) > (32'd1 << (k - 1))) ord = OW'(k);
        big  = 32'(sz) > (32'd1 << MAX_ORDER);
        lowf = NOF;
        for (int k = NUM_FRAMES - 1; k >= 0; k--)
            if (!fin_use_reg[k]) lowf = FW'(k);
    end

    logic [15:0]   ffr;
    logic          fbad;
    logic [PW-1:0] fcls_in;
    assign ffr     = 16'(32'(fa) >> BSH);
    assign fbad    = (32'(ffr) >= NUM_FRAMES) || !fin_use_reg[ffr[FIW-1:0]];
    assign fcls_in = fcls_reg[ffr[FIW-1:0]];

    logic [CW-1:0] sl;
    logic [SW-1:0] smask;
    assign sl    = slots_of(o_reg);
    assign smask = SW'(sl - CW'(1));

    assign stat.busy = (ph_reg != 2'd3);
    assign out_data  = out_reg;

    logic [FW-1:0] h;
    logic [CW-1:0] cnt;
    logic [SW-1:0] fs;
    assign h   = phead_reg[p_reg];
    assign cnt = fcnt_reg[f_reg[FIW-1:0]];
    assign fs  = s_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start) begin
            op_reg <= iop;
            if (iop == OP_ALLOC) begin
                o_reg    <= ord;
                p_reg    <= PW'(32'(icode) * NCLS + 32'(ord) - MIN_ORDER);
                fail_reg <= big;
                st_reg   <= big ? ST_TOO_BIG : ST_OK;
            end else begin
                fail_reg <= fbad;
                st_reg   <= fbad ? ST_BAD_FREE : ST_OK;
                f_reg    <= FW'(ffr);
                fa_reg   <= fa;
                p_reg    <= fcls_in;
                o_reg    <= OW'(MIN_ORDER + ((32'(fcls_in) >= NCLS)
                                             ? 32'(fcls_in) - NCLS : 32'(fcls_in)));
            end
        end
        if (ph_reg == 2'd0 && op_reg == OP_ALLOC && !fail_reg) begin
            newf_reg <= (32'(pcur_reg[p_reg]) >= NUM_FRAMES);
            f_reg    <= (32'(pcur_reg[p_reg]) >= NUM_FRAMES) ? lowf : pcur_reg[p_reg];
            if (32'(pcur_reg[p_reg]) >= NUM_FRAMES && lowf == NOF) begin
                fail_reg <= 1'b1;
                st_reg   <= ST_NO_FRAME;
            end
        end
        if (ph_reg == 2'd0 && op_reg == OP_FREE && !fail_reg)
            s_reg <= SW'((32'(fa_reg) % SLAB_BYTES) >> o_reg) & smask;
        if (ph_reg == 2'd1) begin
            if (op_reg == OP_ALLOC)
                s_reg <= (!newf_reg && !fhnil_reg[f_reg[FIW-1:0]])
                         ? (fhead_reg[f_reg[FIW-1:0]] & smask)
                         : (newf_reg ? '0 : (SW'(fmark_reg[f_reg[FIW-1:0]]) & smask));
            lrd_reg <= link_mem[{f_reg[FIW-1:0], fhead_reg[f_reg[FIW-1:0]] & smask}];
        end
        if (ph_reg == 2'd2 && !fail_reg && op_reg == OP_FREE)
            link_mem[{f_reg[FIW-1:0], s_reg}] <=
                {fhnil_reg[f_reg[FIW-1:0]], fhead_reg[f_reg[FIW-1:0]]};
        if (ph_reg == 2'd2)
            out_reg <= {1'b0, st_reg, 16'd0} | ((op_reg == OP_ALLOC && !fail_reg)
                       ? 19'(16'(32'(f_reg) * SLAB_BYTES + (32'(s_reg) << o_reg))) : 19'd0)
                       | ((op_reg == OP_FREE && !fail_reg &&
                          fcnt_reg[f_reg[FIW-1:0]] + CW'(1) >= sl) ? 19'h40000 : 19'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ph_reg <= 2'd3;
            for (int k = 0; k < NUM_FRAMES; k++) fin_use_reg[k] <= 1'b0;
            for (int k = 0; k < NPOOL; k++)
            begin
                pcur_reg[k]  <= NOF;
                phead_reg[k] <= NOF;
                ptail_reg[k] <= NOF;
            end
        end else begin
            if (cmd.start)
                ph_reg <= 2'd0;
            else if (ph_reg != 2'd3)
                ph_reg <= ph_reg + 2'd1;
            if (ph_reg == 2'd0 && op_reg == OP_ALLOC && !fail_reg &&
                32'(pcur_reg[p_reg]) >= NUM_FRAMES && lowf != NOF) begin
                fin_use_reg[lowf[FIW-1:0]] <= 1'b1;
                fcls_reg[lowf[FIW-1:0]]    <= p_reg;
                fcnt_reg[lowf[FIW-1:0]]    <= sl;
                fhnil_reg[lowf[FIW-1:0]]   <= 1'b1;
                fmark_reg[lowf[FIW-1:0]]   <= '0;
                pcur_reg[p_reg]            <= lowf;
            end
            if (ph_reg == 2'd2 && !fail_reg) begin
                if (op_reg == OP_ALLOC) begin
                    if (!fhnil_reg[f_reg[FIW-1:0]]) begin
                        fhead_reg[f_reg[FIW-1:0]] <= lrd_reg[SW-1:0];
                        fhnil_reg[f_reg[FIW-1:0]] <= lrd_reg[SW];
                    end else
                        fmark_reg[f_reg[FIW-1:0]] <= fmark_reg[f_reg[FIW-1:0]] + CW'(1);
                    fcnt_reg[f_reg[FIW-1:0]] <= cnt - CW'(1);
                    if (cnt == CW'(1)) begin
                        pcur_reg[p_reg] <= h;
                        if (32'(h) < NUM_FRAMES) begin
                            phead_reg[p_reg] <= pnext_reg[h[FIW-1:0]];
                            if (32'(pnext_reg[h[FIW-1:0]]) < NUM_FRAMES)
                                pprev_reg[pnext_reg[h[FIW-1:0]][FIW-1:0]] <=
                                    pprev_reg[h[FIW-1:0]];
                            else
                                ptail_reg[p_reg] <= pprev_reg[h[FIW-1:0]];
                        end
                    end
                end else begin
                    fhead_reg[f_reg[FIW-1:0]] <= fs;
                    fhnil_reg[f_reg[FIW-1:0]] <= 1'b0;
                    fcnt_reg[f_reg[FIW-1:0]]  <= cnt + CW'(1);
                    if (cnt + CW'(1) >= sl) begin
                        fin_use_reg[f_reg[FIW-1:0]] <= 1'b0;
                        if (cnt == '0) begin
                            // slab goes from full to empty: never on a list
                            if (pcur_reg[p_reg] == f_reg) begin
                                pcur_reg[p_reg] <= h;
                                if (32'(h) < NUM_FRAMES) begin
                                    phead_reg[p_reg] <= pnext_reg[h[FIW-1:0]];
                                    if (32'(pnext_reg[h[FIW-1:0]]) < NUM_FRAMES)
                                        pprev_reg[pnext_reg[h[FIW-1:0]][FIW-1:0]] <=
                                            pprev_reg[h[FIW-1:0]];
                                    else
                                        ptail_reg[p_reg] <= pprev_reg[h[FIW-1:0]];
                                end
                            end
                        end else if (pcur_reg[p_reg] == f_reg) begin
                            pcur_reg[p_reg] <= h;
                            if (32'(h) < NUM_FRAMES) begin
                                phead_reg[p_reg] <= pnext_reg[h[FIW-1:0]];
                                if (32'(pnext_reg[h[FIW-1:0]]) < NUM_FRAMES)
                                    pprev_reg[pnext_reg[h[FIW-1:0]][FIW-1:0]] <=
                                        pprev_reg[h[FIW-1:0]];
                                else
                                    ptail_reg[p_reg] <= pprev_reg[h[FIW-1:0]];
                            end
                        end else begin
                            if (32'(pprev_reg[f_reg[FIW-1:0]]) < NUM_FRAMES)
                                pnext_reg[pprev_reg[f_reg[FIW-1:0]][FIW-1:0]] <=
                                    pnext_reg[f_reg[FIW-1:0]];
                            else
                                phead_reg[p_reg] <= pnext_reg[f_reg[FIW-1:0]];
                            if (32'(pnext_reg[f_reg[FIW-1:0]]) < NUM_FRAMES)
                                pprev_reg[pnext_reg[f_reg[FIW-1:0]][FIW-1:0]] <=
                                    pprev_reg[f_reg[FIW-1:0]];
                            else
                                ptail_reg[p_reg] <= pprev_reg[f_reg[FIW-1:0]];
                        end
                    end else if (cnt == '0) begin
                        pnext_reg[f_reg[FIW-1:0]] <= NOF;
                        pprev_reg[f_reg[FIW-1:0]] <= ptail_reg[p_reg];
                        if (32'(ptail_reg[p_reg]) >= NUM_FRAMES)
                            phead_reg[p_reg] <= f_reg;
                        else
                            pnext_reg[ptail_reg[p_reg][FIW-1:0]] <= f_reg;
                        ptail_reg[p_reg] <= f_reg;
                    end
                end
            end
        end
    end

endmodule

### rtl/core/slab_allocator.sv
// ----------------------------------------------------------------------------
// slab_allocator
// Power-of-two class slab allocator, code and data pools per class.
// ----------------------------------------------------------------------------
// One request is in flight at a time. The result is offered after the input
// transfer once it has passed frame lookup, link memory read, bookkeeping commit
// with the result register, and a hand-off step in the sequencer. A new request is
// taken the cycle after the result transfer, so a stalled result stalls the
// input.
module slab_allocator
    import slab_pkg::*;
#(
    parameter int MIN_ORDER  = 4,
    parameter int MAX_ORDER  = 11,
    parameter int SLAB_BYTES = 4096,
    parameter int NUM_FRAMES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // request_size, code_pool, free_address
    input  logic        s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // slot_address, status, frame_released
);

    slab_cmd_t  cmd;
    slab_stat_t stat;
    logic [18:0] res;

    slab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    slab_dp #(
        .MIN_ORDER  (MIN_ORDER),
        .MAX_ORDER  (MAX_ORDER),
        .SLAB_BYTES (SLAB_BYTES),
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  ({s_tdata[32:17], s_tdata[16], s_tdata[15:0], s_tuser}),
        .out_data (res)
    );

    assign m_tdata = {5'd0, res};

endmodule
